// ----- rtl/ecd_pkg.sv -----
// shared constants for the epoch seconds to calendar date pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package ecd_pkg;

  localparam int SECONDS_WIDTH_DEF = 34;

  // output field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // 86400 = 128 * 675: low 7 bits pass by, the rest goes through long division
  localparam int DAY_SHIFT = 7;
  localparam int DAY_DIV   = 675;
  localparam int SOD_W     = 17;
  localparam int BITS_PER_STAGE = 4;

  // days from 0000-03-01 to 1970-01-01
  localparam int CIVIL_OFFSET = 719468;
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;

  // reciprocal constants: q = (x * M) >> S is exact over the input range
  localparam int S_HOUR = 29;
  localparam logic [17:0] M_HOUR = 18'((64'd1 << S_HOUR) / 64'd3600 + 64'd1);
  localparam int S_D1460 = 29;
  localparam logic [18:0] M_D1460 = 19'((64'd1 << S_D1460) / 64'd1460 + 64'd1);
  localparam int S_D36524 = 34;
  localparam logic [18:0] M_D36524 = 19'((64'd1 << S_D36524) / 64'd36524 + 64'd1);
  localparam int S_D146096 = 36;
  localparam logic [18:0] M_D146096 = 19'((64'd1 << S_D146096) / 64'd146096 + 64'd1);
  localparam int S_D365 = 27;
  localparam logic [18:0] M_D365 = 19'((64'd1 << S_D365) / 64'd365 + 64'd1);
  localparam int S_D60 = 18;
  localparam logic [12:0] M_D60 = 13'((64'd1 << S_D60) / 64'd60 + 64'd1);
  localparam int S_D100 = 16;
  localparam logic [9:0] M_D100 = 10'((64'd1 << S_D100) / 64'd100 + 64'd1);
  localparam int S_D153 = 19;
  localparam logic [11:0] M_D153 = 12'((64'd1 << S_D153) / 64'd153 + 64'd1);

  // first day of month index mp (march = 0) within the march-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    begin
      unique case (mp)
        4'd0:    r = 9'd0;
        4'd1:    r = 9'd31;
        4'd2:    r = 9'd61;
        4'd3:    r = 9'd92;
        4'd4:    r = 9'd122;
        4'd5:    r = 9'd153;
        4'd6:    r = 9'd184;
        4'd7:    r = 9'd214;
        4'd8:    r = 9'd245;
        4'd9:    r = 9'd275;
        4'd10:   r = 9'd306;
        4'd11:   r = 9'd337;
        default: r = 9'd0;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ecd_daydiv.sv -----
// pipelined restoring division of epoch seconds into whole days and second of day
// depends on ecd_pkg
`default_nettype none

module ecd_daydiv #(
  parameter int SECONDS_WIDTH = ecd_pkg::SECONDS_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [SECONDS_WIDTH-1:0]   seconds,
  output logic                            out_valid,
  output logic [SECONDS_WIDTH-17:0]       days,
  output logic [ecd_pkg::SOD_W-1:0]       sod
);
  import ecd_pkg::*;

  localparam int NW = SECONDS_WIDTH - DAY_SHIFT;
  localparam int NS = (NW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int PW = NS * BITS_PER_STAGE;
  localparam int DW = SECONDS_WIDTH - 16;

  logic [PW-1:0]        wk  [NS+1];
  logic [9:0]           rm  [NS+1];
  logic [DAY_SHIFT-1:0] lo  [NS+1];
  logic                 vld [NS+1];

  assign wk[0]  = PW'(seconds[SECONDS_WIDTH-1:DAY_SHIFT]);
  assign rm[0]  = '0;
  assign lo[0]  = seconds[DAY_SHIFT-1:0];
  assign vld[0] = in_valid;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [9:0]    r;
    logic [PW-1:0] w;
    logic [10:0]   t;

    // four quotient bits per stage, dividend shifts out the top
    always_comb begin
      r = rm[g];
      w = wk[g];
      t = '0;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        t = {r, w[PW-1]};
        w = {w[PW-2:0], 1'b0};
        if (t >= 11'(DAY_DIV)) begin
          t = t - 11'(DAY_DIV);
          w[0] = 1'b1;
        end
        r = t[9:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wk[g+1] <= w;
        rm[g+1] <= r;
        lo[g+1] <= lo[g];
      end
    end
  end

  assign out_valid = vld[NS];
  assign days      = wk[NS][DW-1:0];
  assign sod       = {rm[NS], lo[NS]};

endmodule

`default_nettype wire

// ----- rtl/ecd_civil.sv -----
// pipeline from day count and second of day to calendar date and time of day
// depends on ecd_pkg
`default_nettype none

module ecd_civil #(
  parameter int SECONDS_WIDTH = ecd_pkg::SECONDS_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [SECONDS_WIDTH-17:0]     days,
  input  wire logic [ecd_pkg::SOD_W-1:0]     sod,
  output logic                               out_valid,
  output logic [ecd_pkg::YEAR_W-1:0]         year,
  output logic [ecd_pkg::MONTH_W-1:0]        month,
  output logic [ecd_pkg::DAY_W-1:0]          day_of_month,
  output logic [ecd_pkg::HOUR_W-1:0]         hour,
  output logic [ecd_pkg::MINUTE_W-1:0]       minute,
  output logic [ecd_pkg::SECOND_W-1:0]       second
);
  import ecd_pkg::*;

  localparam int DW = SECONDS_WIDTH - 16;
  localparam int ZW = ((DW > 20) ? DW : 20) + 1;
  localparam int EW = ZW - 17;
  localparam int YW = EW + 10;
  localparam int S_ERA = ZW + 18;
  localparam logic [ZW:0] M_ERA = (ZW+1)'((64'd1 << S_ERA) / 64'd146097 + 64'd1);

  logic [6:0] v;

  // stage 1
  logic [ZW-1:0]    z1;
  logic [SOD_W-1:0] sod1;
  // stage 2
  logic [ZW-1:0]    z2;
  logic [EW-1:0]    era2;
  logic [SOD_W-1:0] sod2;
  logic [4:0]       hr2;
  // stage 3
  logic [17:0]      doe3;
  logic [EW-1:0]    era3;
  logic [11:0]      ms3;
  logic [4:0]       hr3;
  // stage 4
  logic [17:0]      yn4, doe4;
  logic [EW-1:0]    era4;
  logic [11:0]      ms4;
  logic [5:0]       mi4;
  logic [4:0]       hr4;
  // stage 5
  logic [8:0]       yoe5;
  logic [17:0]      doe5;
  logic [EW-1:0]    era5;
  logic [5:0]       sc5, mi5;
  logic [4:0]       hr5;
  // stage 6
  logic [8:0]       doy6, yoe6;
  logic [EW-1:0]    era6;
  logic [5:0]       sc6, mi6;
  logic [4:0]       hr6;
  // stage 7
  logic [3:0]       mp7;
  logic [8:0]       doy7, yoe7;
  logic [EW-1:0]    era7;
  logic [5:0]       sc7, mi7;
  logic [4:0]       hr7;

  logic [2*ZW:0]    p_era;
  logic [34:0]      p_hour;
  logic [ZW-1:0]    era_days;
  logic [36:0]      p_1460, p_36524, p_146096, p_365;
  logic [24:0]      p_60;
  logic [18:0]      p_100;
  logic [17:0]      yr365;
  logic [10:0]      x153;
  logic [22:0]      p_153;
  logic [8:0]       doy0;
  logic [3:0]       mon8;
  logic [YW-1:0]    yr8;

  assign p_era    = z1 * M_ERA;
  assign p_hour   = sod1 * M_HOUR;
  assign era_days = ZW'(era2) * ZW'(DAYS_PER_ERA);
  assign p_1460   = doe3 * M_D1460;
  assign p_36524  = doe3 * M_D36524;
  assign p_146096 = doe3 * M_D146096;
  assign p_60     = ms3 * M_D60;
  assign p_365    = yn4 * M_D365;
  assign p_100    = yoe5 * M_D100;
  assign yr365    = 18'(yoe5) * 18'd365;
  assign x153     = 11'(doy6) * 11'd5 + 11'd2;
  assign p_153    = x153 * M_D153;
  assign doy0     = month_start(mp7);
  // march-based months: mp 10 and 11 are january and february of the next year
  assign mon8     = (mp7 < 4'd10) ? mp7 + 4'd3 : mp7 - 4'd9;
  assign yr8      = YW'(era7) * YW'(400) + YW'(yoe7) + YW'(mp7 >= 4'd10);

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[5:0], in_valid};
      out_valid <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1   <= ZW'(days) + ZW'(CIVIL_OFFSET);
      sod1 <= sod;

      z2   <= z1;
      era2 <= p_era[S_ERA +: EW];
      sod2 <= sod1;
      hr2  <= p_hour[S_HOUR +: 5];

      doe3 <= 18'(z2 - era_days);
      era3 <= era2;
      ms3  <= 12'(sod2 - SOD_W'(hr2) * SOD_W'(3600));
      hr3  <= hr2;

      // year of era with leap days removed
      yn4  <= doe3 - 18'(p_1460[S_D1460 +: 7]) + 18'(p_36524[S_D36524 +: 3])
              - 18'(p_146096[S_D146096]);
      doe4 <= doe3;
      era4 <= era3;
      ms4  <= ms3;
      mi4  <= p_60[S_D60 +: 6];
      hr4  <= hr3;

      yoe5 <= p_365[S_D365 +: 9];
      doe5 <= doe4;
      era5 <= era4;
      sc5  <= 6'(ms4 - 12'(mi4) * 12'd60);
      mi5  <= mi4;
      hr5  <= hr4;

      doy6 <= 9'(doe5 - (yr365 + 18'(yoe5[8:2]) - 18'(p_100[S_D100 +: 2])));
      yoe6 <= yoe5;
      era6 <= era5;
      sc6  <= sc5;
      mi6  <= mi5;
      hr6  <= hr5;

      mp7  <= p_153[S_D153 +: 4];
      doy7 <= doy6;
      yoe7 <= yoe6;
      era7 <= era6;
      sc7  <= sc6;
      mi7  <= mi6;
      hr7  <= hr6;

      year         <= yr8[YEAR_W-1:0];
      month        <= mon8;
      day_of_month <= DAY_W'(doy7 - doy0 + 9'd1);
      hour         <= hr7;
      minute       <= mi7;
      second       <= sc7;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/epoch_seconds_to_calendar_date_top.sv -----
// Epoch seconds to Gregorian date and time of day.
// Slave channel s_*: one beat carries a count of seconds since 1970-01-01 00:00:00.
// Master channel m_*: one beat per input with year, month, day, hour, minute, second.
// The whole block is one pipeline under a common enable: a new beat may enter
// in every cycle unless the output stalls, so throughput is one beat per cycle.
// The day division takes ceil((SECONDS_WIDTH - 7) / 4) stages, 7 at the default
// width of 34 bits (four quotient bits per stage), then eight stages do the
// era, year, month and time-of-day arithmetic.
// When the receiver holds m_tready low with m_tvalid high, every stage freezes
// and s_tready drops in the same cycle; nothing is lost or repeated, and the
// pipeline resumes where it stopped.
// Synchronous reset clears all valid bits; data registers are not cleared.
// Years past 4095 (possible only at widths above 34) wrap to their low 12 bits.
// Depends on ecd_pkg, ecd_daydiv and ecd_civil.
`default_nettype none

module epoch_seconds_to_calendar_date_top #(
  parameter int SECONDS_WIDTH = ecd_pkg::SECONDS_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // seconds_since_epoch from bit 0, zero padded to whole bytes
  input  wire logic [((SECONDS_WIDTH+7)/8)*8-1:0]    s_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // year[11:0], month[15:12], day_of_month[20:16], hour[25:21],
  // minute[31:26], second[37:32], zero [39:38]
  output logic [39:0]                                m_tdata
);
  import ecd_pkg::*;

  localparam int DW = SECONDS_WIDTH - 16;

  logic                  en;
  logic                  dv;
  logic [DW-1:0]         days;
  logic [SOD_W-1:0]      sod;
  logic [YEAR_W-1:0]     year;
  logic [MONTH_W-1:0]    month;
  logic [DAY_W-1:0]      day_of_month;
  logic [HOUR_W-1:0]     hour;
  logic [MINUTE_W-1:0]   minute;
  logic [SECOND_W-1:0]   second;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  ecd_daydiv #(
    .SECONDS_WIDTH(SECONDS_WIDTH)
  ) u_daydiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .seconds   (s_tdata[SECONDS_WIDTH-1:0]),
    .out_valid (dv),
    .days      (days),
    .sod       (sod)
  );

  ecd_civil #(
    .SECONDS_WIDTH(SECONDS_WIDTH)
  ) u_civil (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (dv),
    .days         (days),
    .sod          (sod),
    .out_valid    (m_tvalid),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  assign m_tdata = {2'b00, second, minute, hour, day_of_month, month, year};

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (month >= 4'd1 && month <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (day_of_month >= 5'd1 && day_of_month <= 5'd31))
    else $error("day of month out of range");

  a_february: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && month == 4'd2) |-> day_of_month <= 5'd29)
    else $error("february day past 29");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (hour < 5'd24 && minute < 6'd60 && second < 6'd60))
    else $error("time of day out of range");

endmodule

`default_nettype wire
